// ----- hw/rtl/sorted_insert_list_top_assert.svh -----
// ----------------------------------------------------------------------------
// sorted insert list assertion macros
// shared concurrent check forms, clocked on i_clk, off while in reset
// ----------------------------------------------------------------------------
`ifndef SORTED_INSERT_LIST_TOP_ASSERT_SVH
`define SORTED_INSERT_LIST_TOP_ASSERT_SVH

// condition must hold at the same edge as the trigger
`define SIL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold at the edge after the trigger
`define SIL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/sil_pkg.sv -----
// ----------------------------------------------------------------------------
// sil_pkg
// shared widths, defaults and operation codes of the sorted insert list
// ----------------------------------------------------------------------------
`default_nettype none

package sil_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int IDX_W        = 6;
    localparam int COUNT_OUT_W  = 7;
    localparam int OP_W         = 2;

    // value, index, zero fill to whole bytes
    localparam int IN_TDATA_W   = 40;
    // read_value, count, full_res
    localparam int OUT_TDATA_W  = 40;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

endpackage

`default_nettype wire

// ----- hw/rtl/sil_ram.sv -----
// ----------------------------------------------------------------------------
// sil_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sil_ram #(
    parameter int WIDTH  = sil_pkg::DATA_W,
    parameter int DEPTH  = sil_pkg::CAPACITY_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_insert_list_top.sv -----
// ----------------------------------------------------------------------------
// sorted_insert_list_top
// ascending list of signed 32-bit values with insert, indexed read and clear
// ----------------------------------------------------------------------------
// usage:
//   one command beat in on the s side (tuser = operation, tdata = value and
//   index), exactly one result beat out on the m side (tuser = accepted,
//   tdata = read value, count, full flag).
//   an insert walks down from the top of the list with one shared signed
//   comparator: each stored entry compared costs a ram read, then a compare
//   and a move up one slot if greater; the walk ends at the first entry not
//   greater or at the bottom of the list (an empty list skips it), then the
//   value is written and the result posted. a read costs a ram read and the
//   capture of the registered ram data; clear, a refused insert, an out of
//   range read and an unused opcode go straight to posting the result.
//   one command is worked at a time and s_tready is low while it runs.
//   a finished result sits in the output register; a new command is taken
//   while it waits, and that command's result holds until m_tready frees
//   the register.
//   reset empties the list at once (count to zero); ram contents are left
//   as they are and are only read below the count.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_insert_list_top #(
    parameter int CAPACITY = sil_pkg::CAPACITY_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // value[31:0], index[37:32], zero[39:38]
    input  wire logic [sil_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // operation[1:0]
    input  wire logic [sil_pkg::OP_W-1:0]         i_s_tuser,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // read_value[31:0], count[38:32], full_res[39]
    output logic      [sil_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    // accepted[0]
    output logic      [0:0]                       o_m_tuser
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int DW     = sil_pkg::DATA_W;
    localparam int IW     = sil_pkg::IDX_W;
    localparam int COW    = sil_pkg::COUNT_OUT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_PUT,
        S_DONE
    } t_state;

    t_state                r_state;
    sil_pkg::t_op          r_op;
    logic signed [DW-1:0]  r_val;
    logic [ADDR_W-1:0]     r_idx;
    logic [ADDR_W-1:0]     r_pos;
    logic [CNT_W-1:0]      r_count;
    logic                  r_res_acc;
    logic [DW-1:0]         r_res_rd;
    logic                  r_out_valid;
    logic                  r_out_acc;
    logic [DW-1:0]         r_out_rd;
    logic [COW-1:0]        r_out_count;
    logic                  r_out_full;

    logic                  s_beat;
    sil_pkg::t_op          in_op;
    logic [DW-1:0]         in_val;
    logic [IW-1:0]         in_idx;
    logic [IW+ADDR_W-1:0]  idx_ext;
    logic [IW+CNT_W-1:0]   idx_cmp;
    logic [IW+CNT_W-1:0]   cnt_cmp;
    logic [CNT_W+COW-1:0]  cnt_ext;
    logic [CNT_W+ADDR_W-1:0] cnt_addr;
    logic [CNT_W+ADDR_W-1:0] pos_ext;
    logic                  list_full;
    logic                  out_free;
    logic                  ins_on_full;
    logic                  refused_ok;
    logic                  walk_in_range;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [DW-1:0]         ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [DW-1:0]         ram_rdata;
    logic                  entry_gt;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_beat     = i_s_tvalid && o_s_tready;
    assign in_op      = sil_pkg::t_op'(i_s_tuser);
    assign in_val     = i_s_tdata[DW-1:0];
    assign in_idx     = i_s_tdata[DW+IW-1:DW];

    assign idx_ext    = {{ADDR_W{1'b0}}, in_idx};
    assign idx_cmp    = {{CNT_W{1'b0}}, in_idx};
    assign cnt_cmp    = {{IW{1'b0}}, r_count};
    assign cnt_ext    = {{COW{1'b0}}, r_count};
    assign cnt_addr   = {{ADDR_W{1'b0}}, r_count};
    assign pos_ext    = {{CNT_W{1'b0}}, r_pos};
    assign list_full  = (r_count == CNT_W'(CAPACITY));
    assign out_free   = !r_out_valid || i_m_tready;

    assign ins_on_full   = s_beat && (in_op == sil_pkg::OP_INSERT) && list_full;
    assign refused_ok    = (r_state == S_DONE) && !r_res_acc && list_full;
    assign walk_in_range = (r_pos != '0) && (pos_ext <= cnt_addr);

    // the one comparator shared by every step of the walk
    assign entry_gt   = ($signed(ram_rdata) > r_val);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = r_val;
        ram_raddr = (r_op == sil_pkg::OP_READ) ? r_idx : r_pos - ADDR_W'(1);
        case (r_state)
            S_CMP: begin
                if (r_op == sil_pkg::OP_INSERT && entry_gt) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                end
            end
            S_PUT: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    sil_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY),
        .ADDR_W(ADDR_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // in S_DONE the output register is reloaded instead
            if (r_out_valid && i_m_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_beat) begin
                        r_op      <= in_op;
                        r_val     <= $signed(in_val);
                        r_idx     <= idx_ext[ADDR_W-1:0];
                        r_res_acc <= (in_op == sil_pkg::OP_CLEAR);
                        r_res_rd  <= '0;
                        case (in_op)
                            sil_pkg::OP_INSERT: begin
                                r_pos <= cnt_addr[ADDR_W-1:0];
                                if (list_full) begin
                                    r_state <= S_DONE;
                                end else if (r_count == '0) begin
                                    r_state <= S_PUT;
                                end else begin
                                    r_state <= S_RD;
                                end
                            end
                            sil_pkg::OP_READ: begin
                                r_state <= (idx_cmp < cnt_cmp) ? S_RD : S_DONE;
                            end
                            sil_pkg::OP_CLEAR: begin
                                r_count   <= '0;
                                r_state   <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_op == sil_pkg::OP_READ) begin
                        r_res_acc <= 1'b1;
                        r_res_rd  <= ram_rdata;
                        r_state   <= S_DONE;
                    end else if (entry_gt) begin
                        // entry moved up one slot, keep walking down
                        r_pos   <= r_pos - ADDR_W'(1);
                        r_state <= (r_pos == ADDR_W'(1)) ? S_PUT : S_RD;
                    end else begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    r_count   <= r_count + CNT_W'(1);
                    r_res_acc <= 1'b1;
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_acc   <= r_res_acc;
                        r_out_rd    <= r_res_rd;
                        r_out_count <= cnt_ext[COW-1:0];
                        r_out_full  <= list_full;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_acc;
    assign o_m_tdata  = {r_out_full, r_out_count, r_out_rd};

    `include "sorted_insert_list_top_assert.svh"

    `SIL_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(CAPACITY), "count above capacity")
    `SIL_ASSERT_NEXT(a_full_refused, ins_on_full, refused_ok, "full insert not refused")
    `SIL_ASSERT_NOW(a_walk_pos, (r_state == S_RD || r_state == S_CMP) && r_op == sil_pkg::OP_INSERT, walk_in_range, "walk out of range")
    `SIL_ASSERT_NEXT(a_put_count, r_state == S_PUT, r_count == $past(r_count) + CNT_W'(1), "no raise")

endmodule

`default_nettype wire

// ----- verif/tb_sorted_insert_list_top.sv -----
// ----------------------------------------------------------------------------
// tb_sorted_insert_list_top
// checks the ascending list against a shadow copy kept in the bench: every
// command beat updates the shadow list and queues the result it must give,
// every result beat is compared field by field with the oldest queued one
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sorted_insert_list_top;

    localparam int          LIST_CAP   = sil_pkg::CAPACITY_DEF;
    localparam int          CLK_HALF   = 5;
    localparam int          RAND_ITEMS = 1800;
    localparam int          IW         = sil_pkg::IDX_W;
    localparam logic [1:0]  OP_UNUSED  = 2'd3;

    typedef struct packed {
        logic [sil_pkg::OP_W-1:0]         op;
        logic [sil_pkg::DATA_W-1:0]       value;
        logic [sil_pkg::IDX_W-1:0]        index;
    } t_list_cmd;

    typedef struct packed {
        logic                             accepted;
        logic [sil_pkg::DATA_W-1:0]       read_value;
        logic [sil_pkg::COUNT_OUT_W-1:0]  count;
        logic                             full;
    } t_list_result;

    logic                              clk    = 1'b0;
    logic                              rst_n  = 1'b0;
    logic                              s_vld  = 1'b0;
    logic [sil_pkg::IN_TDATA_W-1:0]    s_data = '0;
    logic [sil_pkg::OP_W-1:0]          s_user = '0;
    logic                              m_rdy  = 1'b0;
    logic                              s_rdy;
    logic                              m_vld;
    logic [sil_pkg::OUT_TDATA_W-1:0]   m_data;
    logic [0:0]                        m_user;

    t_list_cmd      cmd_q[$];
    t_list_result   result_q[$];

    // shadow of the list held in the block
    logic signed [sil_pkg::DATA_W-1:0] shadow_list [LIST_CAP];
    int                                shadow_len = 0;

    bit s_took     = 1'b0;
    int gap_pct    = 38;
    int issued_cnt = 0;
    int sent_cnt   = 0;
    int gen_len    = 0;
    int err_cnt    = 0;
    int n_ins_ok   = 0;
    int n_ins_full = 0;
    int n_rd_ok    = 0;
    int n_rd_miss  = 0;
    int n_clear    = 0;
    int n_bad_op   = 0;

    always #(CLK_HALF) clk = ~clk;

    sorted_insert_list_top #(
        .CAPACITY   (LIST_CAP)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_vld),
        .o_s_tready (s_rdy),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .o_m_tvalid (m_vld),
        .i_m_tready (m_rdy),
        .o_m_tdata  (m_data),
        .o_m_tuser  (m_user)
    );

    function automatic t_list_result apply_cmd(logic [sil_pkg::OP_W-1:0] op,
                                               logic signed [sil_pkg::DATA_W-1:0] val,
                                               logic [sil_pkg::IDX_W-1:0] idx);
        t_list_result r;
        int           pos;
        int           j;
        r = '0;
        case (op)
            sil_pkg::OP_INSERT: begin
                if (shadow_len < LIST_CAP) begin
                    // equal values stay ahead of the new one
                    pos = 0;
                    while (pos < shadow_len && !(shadow_list[pos] > val))
                        pos++;
                    for (j = shadow_len; j > pos; j--)
                        shadow_list[j] = shadow_list[j-1];
                    shadow_list[pos] = val;
                    shadow_len++;
                    r.accepted = 1'b1;
                    n_ins_ok++;
                end else begin
                    n_ins_full++;
                end
            end
            sil_pkg::OP_READ: begin
                if (int'(idx) < shadow_len) begin
                    r.accepted   = 1'b1;
                    r.read_value = shadow_list[idx];
                    n_rd_ok++;
                end else begin
                    n_rd_miss++;
                end
            end
            sil_pkg::OP_CLEAR: begin
                shadow_len = 0;
                r.accepted = 1'b1;
                n_clear++;
            end
            default: n_bad_op++;
        endcase
        r.count = shadow_len[sil_pkg::COUNT_OUT_W-1:0];
        r.full  = (shadow_len == LIST_CAP);
        return r;
    endfunction

    // driver: a beat stays up until taken, then the next one may follow
    always @(negedge clk) begin
        t_list_cmd nxt;
        if (!rst_n) begin
            s_vld <= 1'b0;
            m_rdy <= 1'b0;
        end else begin
            if (!s_vld || s_took) begin
                if (cmd_q.size() != 0 && $urandom_range(99, 0) >= gap_pct) begin
                    nxt    = cmd_q.pop_front();
                    s_vld  <= 1'b1;
                    s_data <= {2'b00, nxt.index, nxt.value};
                    s_user <= nxt.op;
                end else begin
                    s_vld <= 1'b0;
                end
            end
            m_rdy <= ($urandom_range(99, 0) >= gap_pct);
        end
    end

    // monitor: compare the result beat first, then record the command beat
    always @(posedge clk) begin
        t_list_result want;
        t_list_result got;
        s_took = 1'b0;
        if (rst_n) begin
            if (m_vld && m_rdy) begin
                got.accepted   = m_user[0];
                got.read_value = m_data[31:0];
                got.count      = m_data[38:32];
                got.full       = m_data[39];
                if (result_q.size() == 0) begin
                    $error("result beat with nothing outstanding");
                    err_cnt++;
                end else begin
                    want = result_q.pop_front();
                    if (got.accepted !== want.accepted) begin
                        $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
                        err_cnt++;
                    end
                    if (got.read_value !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               $signed(want.read_value), $signed(got.read_value));
                        err_cnt++;
                    end
                    if (got.count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, got.count);
                        err_cnt++;
                    end
                    if (got.full !== want.full) begin
                        $error("full_res: expected %0d, got %0d", want.full, got.full);
                        err_cnt++;
                    end
                end
            end
            if (s_vld && s_rdy) begin
                s_took = 1'b1;
                result_q.push_back(apply_cmd(s_user, s_data[31:0], s_data[37:32]));
                sent_cnt++;
            end
        end
    end

    task automatic queue_cmd(logic [sil_pkg::OP_W-1:0] op, logic [sil_pkg::DATA_W-1:0] val,
                             logic [sil_pkg::IDX_W-1:0] idx);
        t_list_cmd c;
        c.op    = op;
        c.value = val;
        c.index = idx;
        cmd_q.push_back(c);
        issued_cnt++;
        if (op == sil_pkg::OP_INSERT && gen_len < LIST_CAP)
            gen_len++;
        else if (op == sil_pkg::OP_CLEAR)
            gen_len = 0;
    endtask

    // mostly inside the stored range, sometimes anywhere
    task automatic queue_read();
        if (gen_len > 0 && $urandom_range(99, 0) < 80)
            queue_cmd(sil_pkg::OP_READ, $urandom, IW'($urandom_range(gen_len - 1, 0)));
        else
            queue_cmd(sil_pkg::OP_READ, $urandom, IW'($urandom_range(63, 0)));
    endtask

    function automatic logic [sil_pkg::DATA_W-1:0] pick_value(int mode);
        logic [sil_pkg::DATA_W-1:0] corner [7];
        corner = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                   32'h1, 32'h8000_0001, 32'h7fff_fffe};
        case (mode)
            0: return $urandom;
            // narrow range gives plenty of equal values
            1: return $urandom_range(16, 0) - 8;
            2: return corner[$urandom_range(6, 0)];
            default: return ($urandom_range(1, 0) != 0) ? $urandom
                                                         : corner[$urandom_range(6, 0)];
        endcase
    endfunction

    task automatic run_episodes(int upto, bit fill_first);
        int target;
        int mode;
        int k;
        bit fill;
        fill = fill_first;
        while (issued_cnt < upto) begin
            mode = $urandom_range(3, 0);
            if (fill || $urandom_range(3, 0) == 0)
                target = LIST_CAP + $urandom_range(4, 1);
            else
                target = $urandom_range(40, 1);
            fill = 1'b0;
            if ($urandom_range(4, 0) != 0)
                queue_cmd(sil_pkg::OP_CLEAR, $urandom, IW'($urandom_range(63, 0)));
            for (k = 0; k < target; k++) begin
                queue_cmd(sil_pkg::OP_INSERT, pick_value(mode), IW'($urandom_range(63, 0)));
                if ($urandom_range(99, 0) < 30)
                    queue_read();
                if ($urandom_range(99, 0) < 3)
                    queue_cmd(OP_UNUSED, $urandom, IW'($urandom_range(63, 0)));
                if ($urandom_range(999, 0) < 5)
                    queue_cmd(sil_pkg::OP_CLEAR, $urandom, IW'($urandom_range(63, 0)));
            end
            repeat ($urandom_range(6, 0)) queue_read();
        end
    endtask

    task automatic wait_drained();
        while (!(sent_cnt == issued_cnt && result_q.size() == 0))
            @(negedge clk);
    endtask

    initial begin
        int i;
        int base;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty list, extremes, duplicates, reads across and past the count
        queue_cmd(sil_pkg::OP_READ, 32'h0, 6'd0);
        queue_cmd(sil_pkg::OP_READ, 32'hffff_ffff, 6'd63);
        queue_cmd(sil_pkg::OP_INSERT, 32'h0, 6'd0);
        queue_cmd(sil_pkg::OP_INSERT, 32'h7fff_ffff, 6'd63);
        queue_cmd(sil_pkg::OP_INSERT, 32'h8000_0000, 6'd0);
        queue_cmd(sil_pkg::OP_INSERT, 32'hffff_ffff, 6'd0);
        queue_cmd(sil_pkg::OP_INSERT, 32'h0, 6'd0);
        queue_cmd(sil_pkg::OP_INSERT, 32'h1, 6'd0);
        queue_cmd(sil_pkg::OP_INSERT, 32'h8000_0000, 6'd0);
        for (i = 0; i < 8; i++)
            queue_cmd(sil_pkg::OP_READ, 32'h0, i[IW-1:0]);
        queue_cmd(sil_pkg::OP_READ, 32'h0, 6'd7);
        queue_cmd(sil_pkg::OP_READ, 32'h0, 6'd63);
        queue_cmd(OP_UNUSED, 32'hffff_ffff, 6'd63);
        queue_cmd(sil_pkg::OP_CLEAR, 32'hffff_ffff, 6'd63);
        queue_cmd(sil_pkg::OP_READ, 32'h0, 6'd0);
        wait_drained();

        base = issued_cnt;
        run_episodes(base + 700, 1'b1);
        wait_drained();
        gap_pct = 0;
        run_episodes(base + 1100, 1'b0);
        wait_drained();
        gap_pct = 38;
        run_episodes(base + RAND_ITEMS, 1'b0);
        wait_drained();
        repeat (2 * LIST_CAP + 10) @(posedge clk);

        $display("%0d commands: %0d inserts stored, %0d refused on a full list, %0d clears",
                 sent_cnt, n_ins_ok, n_ins_full, n_clear);
        $display("%0d reads in range, %0d out of range, %0d unused opcodes, %0d mismatches",
                 n_rd_ok, n_rd_miss, n_bad_op, err_cnt);
        if (err_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
